FILE: hdl/ddo_pkg.sv
`default_nettype none
package ddo_pkg;

    localparam int unsigned MAC_A_W   = 35;
    localparam int unsigned MAC_B_W   = 64;
    localparam int unsigned MAC_ACC_W = 68;
    localparam int unsigned CHUNK_W   = 16;
    localparam int unsigned TRIG_W    = 34;

    // round(2^32 / (2 pi))
    localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
    // 1 / CORDIC gain in Q4.30
    localparam logic signed [TRIG_W-1:0] CORDIC_X0 = 34'sd652032874;

    localparam logic [2:0] REG_METERS_PER_STEP = 3'd0;
    localparam logic [2:0] REG_INV_BASE_WIDTH  = 3'd1;
    localparam logic [2:0] REG_INVERT_FIRST    = 3'd2;
    localparam logic [2:0] REG_INVERT_SECOND   = 3'd3;
    localparam logic [2:0] REG_SWAP_SIDES      = 3'd4;

    typedef struct packed {
        logic       start;
        logic [2:0] chunks;
    } t_mac_req;

    // arctangent of 2^-i in binary-angle units
    function automatic logic [29:0] atan_bam(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933406;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85004756;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10679848;
            5'd7:  v = 30'd5340245;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41722;
            5'd15: v = 30'd20861;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2608;
            5'd19: v = 30'd1304;
            5'd20: v = 30'd652;
            5'd21: v = 30'd326;
            5'd22: v = 30'd163;
            5'd23: v = 30'd81;
            5'd24: v = 30'd41;
            5'd25: v = 30'd20;
            5'd26: v = 30'd10;
            5'd27: v = 30'd5;
            5'd28: v = 30'd3;
            5'd29: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/ddo_mac.sv
`default_nettype none
module ddo_mac (
    input  wire                                       i_clk,
    input  wire                                       i_rst_n,
    input  ddo_pkg::t_mac_req                         i_req,
    input  wire signed [ddo_pkg::MAC_A_W-1:0]         i_a,
    input  wire signed [ddo_pkg::MAC_B_W-1:0]         i_b,
    output logic signed [ddo_pkg::MAC_ACC_W-1:0]      o_acc,
    output logic                                      o_done
);

    logic signed [ddo_pkg::MAC_A_W-1:0]   r_a;
    logic        [ddo_pkg::MAC_B_W-1:0]   r_b;
    logic signed [ddo_pkg::MAC_ACC_W-1:0] r_acc;
    logic [2:0]                           r_cnt;
    logic                                 r_first;
    logic                                 r_busy;
    logic                                 r_done;
    logic signed [ddo_pkg::CHUNK_W:0]     chunk;
    logic signed [ddo_pkg::MAC_A_W+ddo_pkg::CHUNK_W:0] prod;

    // top chunk is signed, lower chunks are unsigned
    assign chunk = r_first ? {r_b[63], r_b[63:48]} : {1'b0, r_b[63:48]};
    assign prod  = r_a * chunk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_a     <= i_a;
                r_b     <= i_b << {3'd4 - i_req.chunks, 4'd0};
                r_cnt   <= i_req.chunks;
                r_first <= 1'b1;
                r_acc   <= '0;
            end else if (r_busy) begin
                r_acc   <= {r_acc[51:0], 16'h0000} + {{16{prod[51]}}, prod};
                r_b     <= r_b << ddo_pkg::CHUNK_W;
                r_first <= 1'b0;
                r_cnt   <= r_cnt - 3'd1;
                if (r_cnt == 3'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_acc  = r_acc;
    assign o_done = r_done;

endmodule
`default_nettype wire

FILE: hdl/ddo_cordic.sv
`default_nettype none
module ddo_cordic #(
    parameter int TRIG_ITERATIONS = 16
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_start,
    input  wire  [31:0]                           i_angle,
    output logic signed [ddo_pkg::TRIG_W-1:0]     o_cos,
    output logic signed [ddo_pkg::TRIG_W-1:0]     o_sin,
    output logic                                  o_done
);

    localparam logic [4:0] LAST = 5'(TRIG_ITERATIONS - 1);

    logic signed [ddo_pkg::TRIG_W-1:0] r_x, r_y, r_z;
    logic [4:0]                        r_i;
    logic                              r_flip;
    logic                              r_busy;
    logic                              r_done;
    logic                              flip;
    logic [31:0]                       folded;
    logic signed [ddo_pkg::TRIG_W-1:0] dx, dy, at;

    // fold the left half plane onto the right one and negate at the end
    assign flip   = i_angle[31] ^ i_angle[30];
    assign folded = flip ? i_angle + 32'h8000_0000 : i_angle;
    assign dx     = r_y >>> r_i;
    assign dy     = r_x >>> r_i;
    assign at     = {4'b0, ddo_pkg::atan_bam(r_i)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_x    <= ddo_pkg::CORDIC_X0;
                r_y    <= '0;
                r_z    <= {{2{folded[31]}}, folded};
                r_flip <= flip;
                r_i    <= '0;
            end else if (r_busy) begin
                if (!r_z[ddo_pkg::TRIG_W-1]) begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - at;
                end else begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + at;
                end
                r_i <= r_i + 5'd1;
                if (r_i == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_cos  = r_flip ? -r_x : r_x;
    assign o_sin  = r_flip ? -r_y : r_y;
    assign o_done = r_done;

endmodule
`default_nettype wire

FILE: hdl/diff_drive_odometry_top.sv
// The input is ready only while the sequencer is idle, so a new item is taken only once the
// last one has passed through the shared 35x17 multiply-accumulate and the CORDIC loop and
// its result is in the output register, where it waits while the next item is taken.
// Reset (synchronous, active low) clears pose, previous counts and registers
// to their defaults.
`default_nettype none
module diff_drive_odometry_top #(
    parameter int TRIG_ITERATIONS = 16
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [63:0]  s_axis_tdata,   // first_count[31:0], second_count[63:32]
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // pos_x[31:0], pos_y[63:32], heading[95:64], orient_z[111:96], orient_w[127:112]
    output logic [127:0] m_axis_tdata,
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire  [4:0]   paddr,
    input  wire  [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    typedef enum logic [4:0] {
        S_IDLE, S_UW_GO, S_UW_WT, S_UP_GO, S_UP_WT, S_Q_GO, S_Q_WT, S_H_GO, S_H_WT,
        S_C1_GO, S_C1_WT, S_X_GO, S_X_WT, S_Y_GO, S_Y_WT, S_C2_GO, S_C2_WT, S_OUT
    } t_state;

    t_state        r_state;
    logic [31:0]   r_mps;
    logic [23:0]   r_ibw;
    logic          r_inv1, r_inv2, r_swap;
    logic [31:0]   r_prev1, r_prev2, r_px, r_py, r_head, r_hd;
    logic signed [32:0] r_sum, r_diff;
    logic signed [31:0] r_uw, r_up;
    logic signed [56:0] r_q;
    logic          r_ovalid;
    logic [127:0]  r_odata;

    logic [31:0]   d1, d2, e1, e2, a1, a2;
    logic          in_acc, cfg_wr, out_load;
    ddo_pkg::t_mac_req mac_req;
    logic signed [ddo_pkg::MAC_A_W-1:0]   mac_a;
    logic signed [ddo_pkg::MAC_B_W-1:0]   mac_b;
    logic signed [ddo_pkg::MAC_ACC_W-1:0] mac_acc;
    logic          mac_done;
    logic          cor_start, cor_done;
    logic [31:0]   cor_angle;
    logic signed [ddo_pkg::TRIG_W-1:0] cor_cos, cor_sin;

    function automatic logic [31:0] sat32(input logic signed [51:0] v);
        logic [31:0] r;
        if (v > 52'sd2147483647)       r = 32'h7FFF_FFFF;
        else if (v < -52'sd2147483648) r = 32'h8000_0000;
        else                           r = v[31:0];
        return r;
    endfunction

    function automatic logic [15:0] to_q15(input logic signed [33:0] v);
        logic signed [34:0] t;
        logic signed [19:0] r;
        logic [15:0]        o;
        t = {v[33], v} + 35'sd16384;
        r = t[34:15];
        if (r > 20'sd32767)       o = 16'h7FFF;
        else if (r < -20'sd32768) o = 16'h8000;
        else                      o = r[15:0];
        return o;
    endfunction

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign out_load = (r_state == S_OUT) && (!r_ovalid || m_axis_tready);

    assign d1 = s_axis_tdata[31:0] - r_prev1;
    assign d2 = s_axis_tdata[63:32] - r_prev2;
    assign e1 = r_inv1 ? 32'd0 - d1 : d1;
    assign e2 = r_inv2 ? 32'd0 - d2 : d2;
    assign a1 = r_swap ? e2 : e1;
    assign a2 = r_swap ? e1 : e2;

    always_comb begin
        mac_req.start  = 1'b0;
        mac_req.chunks = 3'd3;
        mac_a = {3'b000, r_mps};
        mac_b = {{31{r_sum[32]}}, r_sum};
        cor_start = 1'b0;
        cor_angle = r_head;
        case (r_state)
            S_UW_GO: mac_req.start = 1'b1;
            S_UP_GO: begin
                mac_req.start = 1'b1;
                mac_b = {{31{r_diff[32]}}, r_diff};
            end
            S_Q_GO: begin
                mac_req.start  = 1'b1;
                mac_req.chunks = 3'd2;
                mac_a = {{3{r_up[31]}}, r_up};
                mac_b = {40'd0, r_ibw};
            end
            S_H_GO: begin
                mac_req.start  = 1'b1;
                mac_req.chunks = 3'd4;
                mac_a = {5'd0, ddo_pkg::INV_TWO_PI_Q32};
                mac_b = {{7{r_q[56]}}, r_q};
            end
            S_X_GO: begin
                mac_req.start = 1'b1;
                mac_a = {{3{r_uw[31]}}, r_uw};
                mac_b = {{30{cor_cos[33]}}, cor_cos};
            end
            S_Y_GO: begin
                mac_req.start = 1'b1;
                mac_a = {{3{r_uw[31]}}, r_uw};
                mac_b = {{30{cor_sin[33]}}, cor_sin};
            end
            S_C1_GO: cor_start = 1'b1;
            S_C2_GO: begin
                cor_start = 1'b1;
                cor_angle = {1'b0, r_head[31:1]};
            end
            default: ;
        endcase
    end

    ddo_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mac_req),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .o_acc   (mac_acc),
        .o_done  (mac_done)
    );

    ddo_cordic #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_angle (cor_angle),
        .o_cos   (cor_cos),
        .o_sin   (cor_sin),
        .o_done  (cor_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_mps    <= 32'd4294967;
            r_ibw    <= 24'd163840;
            r_inv1   <= 1'b0;
            r_inv2   <= 1'b0;
            r_swap   <= 1'b1;
            r_prev1  <= '0;
            r_prev2  <= '0;
            r_px     <= '0;
            r_py     <= '0;
            r_head   <= '0;
        end else begin
            if (cfg_wr) begin
                case (paddr[4:2])
                    ddo_pkg::REG_METERS_PER_STEP: r_mps  <= pwdata;
                    ddo_pkg::REG_INV_BASE_WIDTH:  r_ibw  <= pwdata[23:0];
                    ddo_pkg::REG_INVERT_FIRST:    r_inv1 <= pwdata[0];
                    ddo_pkg::REG_INVERT_SECOND:   r_inv2 <= pwdata[0];
                    ddo_pkg::REG_SWAP_SIDES:      r_swap <= pwdata[0];
                    default: ;
                endcase
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: if (in_acc) begin
                    r_prev1 <= s_axis_tdata[31:0];
                    r_prev2 <= s_axis_tdata[63:32];
                    r_sum   <= {a1[31], a1} + {a2[31], a2};
                    r_diff  <= {a2[31], a2} - {a1[31], a1};
                    r_state <= S_UW_GO;
                end
                S_UW_GO: r_state <= S_UW_WT;
                S_UW_WT: if (mac_done) begin
                    r_uw    <= sat32($signed(mac_acc[67:16]) >>> 1);
                    r_state <= S_UP_GO;
                end
                S_UP_GO: r_state <= S_UP_WT;
                S_UP_WT: if (mac_done) begin
                    r_up    <= sat32(mac_acc[67:16]);
                    r_state <= S_Q_GO;
                end
                S_Q_GO: r_state <= S_Q_WT;
                S_Q_WT: if (mac_done) begin
                    r_q     <= mac_acc[56:0];
                    r_state <= S_H_GO;
                end
                S_H_GO: r_state <= S_H_WT;
                S_H_WT: if (mac_done) begin
                    r_hd    <= mac_acc[63:32];
                    r_state <= S_C1_GO;
                end
                S_C1_GO: r_state <= S_C1_WT;
                S_C1_WT: if (cor_done) r_state <= S_X_GO;
                S_X_GO:  r_state <= S_X_WT;
                S_X_WT: if (mac_done) begin
                    r_px    <= r_px + mac_acc[61:30];
                    r_state <= S_Y_GO;
                end
                S_Y_GO: r_state <= S_Y_WT;
                S_Y_WT: if (mac_done) begin
                    r_py    <= r_py + mac_acc[61:30];
                    r_head  <= r_head + r_hd;
                    r_state <= S_C2_GO;
                end
                S_C2_GO: r_state <= S_C2_WT;
                S_C2_WT: if (cor_done) r_state <= S_OUT;
                S_OUT: if (out_load) begin
                    r_odata  <= {to_q15(cor_cos), to_q15(cor_sin), r_head, r_py, r_px};
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            ddo_pkg::REG_METERS_PER_STEP: prdata = r_mps;
            ddo_pkg::REG_INV_BASE_WIDTH:  prdata = {8'd0, r_ibw};
            ddo_pkg::REG_INVERT_FIRST:    prdata = {31'd0, r_inv1};
            ddo_pkg::REG_INVERT_SECOND:   prdata = {31'd0, r_inv2};
            ddo_pkg::REG_SWAP_SIDES:      prdata = {31'd0, r_swap};
            default:                      prdata = 32'd0;
        endcase
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

endmodule
`default_nettype wire

FILE: hdl/ddo_checker.sv
`default_nettype none
module ddo_checker (
    input wire          i_clk,
    input wire          i_rst_n,
    input wire          s_axis_tvalid,
    input wire          s_axis_tready,
    input wire          m_axis_tvalid,
    input wire          m_axis_tready,
    input wire [127:0]  m_axis_tdata,
    input wire          pready
);

    // result register empties on reset
    a_rst_clear: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // sequencer goes busy once a beat is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after accept");

    // no result can appear the cycle after an input beat
    a_no_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("result too early");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready low");

endmodule

bind diff_drive_odometry_top ddo_checker u_ddo_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pready        (pready)
);
`default_nettype wire
